/* rtl/lbcs_pkg.sv */
// Shared types and constants of the linked block chain store.
// No dependencies; used by lbcs_ctrl, lbcs_dp and linked_block_chain_store.
package lbcs_pkg;

  // Width of the internal counters (chain lengths, block counts, byte sums).
  localparam int CW = 13;

  // Request stream layout.
  localparam int IN_W  = 40;
  localparam int OUT_W = 32;

  // Configuration register indexes.
  localparam logic [0:0] CFG_BLOCKS = 1'b0;
  localparam logic [0:0] CFG_FILES  = 1'b1;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_RESIZE = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FILE  = 3'd1,
    ST_NO_BLOCK = 3'd2,
    ST_PAST_END = 3'd3,
    ST_UNUSED   = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_DISPATCH,
    OP_FSCAN,
    OP_CHECK,
    OP_LEN,
    OP_DECIDE,
    OP_COUNT,
    OP_CHKFREE,
    OP_APPEND,
    OP_NTH0,
    OP_NTH,
    OP_CUT0,
    OP_CUT,
    OP_WRITE,
    OP_READ,
    OP_READ2,
    OP_UPDATE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    req_t req_type;
    logic clr_last;
    logic fs_fail;
    logic fs_hit;
    logic chk_bad;
    logic len_more;
    logic need_gt_len;
    logic need_lt_len;
    logic k_ge_len;
    logic cnt_end;
    logic short_free;
    logic app_last;
    logic nth_more;
    logic cut_more;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/lbcs_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module lbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/lbcs_ctrl.sv */
// Request sequencer of the linked block chain store.
// Depends on lbcs_pkg; drives lbcs_dp through cmd_t, watches stat_t.
module lbcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  lbcs_pkg::stat_t stat,
  output lbcs_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_FSCAN, S_CHECK, S_LEN, S_DECIDE, S_COUNT,
    S_CHKFREE, S_APPEND, S_NTH0, S_NTH, S_CUT0, S_CUT, S_WRITE, S_READ,
    S_READ2, S_UPDATE, S_FINISH
  } state_t;

  state_t state, state_next;

  assign s_tready   = (state == S_IDLE);
  assign cmd.accept = s_tvalid && (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_CLEAR:    cmd.op = lbcs_pkg::OP_CLEAR;
      S_IDLE:     cmd.op = lbcs_pkg::OP_IDLE;
      S_DISPATCH: cmd.op = lbcs_pkg::OP_DISPATCH;
      S_FSCAN:    cmd.op = lbcs_pkg::OP_FSCAN;
      S_CHECK:    cmd.op = lbcs_pkg::OP_CHECK;
      S_LEN:      cmd.op = lbcs_pkg::OP_LEN;
      S_DECIDE:   cmd.op = lbcs_pkg::OP_DECIDE;
      S_COUNT:    cmd.op = lbcs_pkg::OP_COUNT;
      S_CHKFREE:  cmd.op = lbcs_pkg::OP_CHKFREE;
      S_APPEND:   cmd.op = lbcs_pkg::OP_APPEND;
      S_NTH0:     cmd.op = lbcs_pkg::OP_NTH0;
      S_NTH:      cmd.op = lbcs_pkg::OP_NTH;
      S_CUT0:     cmd.op = lbcs_pkg::OP_CUT0;
      S_CUT:      cmd.op = lbcs_pkg::OP_CUT;
      S_WRITE:    cmd.op = lbcs_pkg::OP_WRITE;
      S_READ:     cmd.op = lbcs_pkg::OP_READ;
      S_READ2:    cmd.op = lbcs_pkg::OP_READ2;
      S_UPDATE:   cmd.op = lbcs_pkg::OP_UPDATE;
      S_FINISH:   cmd.op = lbcs_pkg::OP_FINISH;
      default:    cmd.op = lbcs_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (stat.clr_last) state_next = S_IDLE;
      S_IDLE:     if (s_tvalid) state_next = S_DISPATCH;
      S_DISPATCH: state_next = (stat.req_type == lbcs_pkg::REQ_ALLOC) ? S_FSCAN : S_CHECK;
      S_FSCAN: begin
        if (stat.fs_fail) state_next = S_UPDATE;
        else if (stat.fs_hit) state_next = S_COUNT;
      end
      S_CHECK:    state_next = stat.chk_bad ? S_UPDATE : S_LEN;
      S_LEN:      if (!stat.len_more) state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (stat.req_type)
          lbcs_pkg::REQ_RESIZE: begin
            if (stat.need_gt_len) state_next = S_COUNT;
            else if (stat.need_lt_len) state_next = S_NTH0;
            else state_next = S_UPDATE;
          end
          lbcs_pkg::REQ_WRITE: state_next = stat.k_ge_len ? S_COUNT : S_NTH0;
          default:             state_next = stat.k_ge_len ? S_UPDATE : S_NTH0;
        endcase
      end
      S_COUNT:    if (stat.cnt_end) state_next = S_CHKFREE;
      S_CHKFREE:  state_next = stat.short_free ? S_UPDATE : S_APPEND;
      S_APPEND: begin
        if (stat.app_last) begin
          state_next = (stat.req_type == lbcs_pkg::REQ_WRITE) ? S_NTH0 : S_UPDATE;
        end
      end
      S_NTH0:     state_next = S_NTH;
      S_NTH: begin
        if (!stat.nth_more) begin
          unique case (stat.req_type)
            lbcs_pkg::REQ_RESIZE: state_next = S_CUT0;
            lbcs_pkg::REQ_WRITE:  state_next = S_WRITE;
            default:              state_next = S_READ;
          endcase
        end
      end
      S_CUT0:     state_next = S_CUT;
      S_CUT:      if (!stat.cut_more) state_next = S_UPDATE;
      S_WRITE:    state_next = S_UPDATE;
      S_READ:     state_next = S_READ2;
      S_READ2:    state_next = S_UPDATE;
      S_UPDATE:   state_next = S_FINISH;
      S_FINISH:   if (!stat.out_busy) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/lbcs_dp.sv */
// Datapath of the linked block chain store: link table, file table,
// byte memory, request and result registers. Depends on lbcs_pkg, lbcs_ram.
module lbcs_dp #(
  parameter int BLOCK_COUNT = 32,
  parameter int BLOCK_BYTES = 32,
  parameter int NUM_FILES   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lbcs_pkg::cmd_t              cmd,
  output lbcs_pkg::stat_t             stat,
  input  logic [lbcs_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lbcs_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        cfg_valid,
  input  logic [0:0]                  cfg_index,
  input  logic [5:0]                  cfg_data
);

  localparam int CW    = lbcs_pkg::CW;
  localparam int BW    = $clog2(BLOCK_COUNT);
  localparam int LW    = BW + 1;
  localparam int FIW   = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int FCW   = $clog2(NUM_FILES + 1);
  localparam int DEPTH = BLOCK_COUNT * BLOCK_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int LOG_B = $clog2(BLOCK_BYTES);
  localparam int SH    = CW + LOG_B;
  localparam int PW    = 2 * CW + 1;
  localparam int RECIP = ((1 << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;

  localparam logic [LW-1:0] LINK_FREE = {LW{1'b1}};
  localparam logic [LW-1:0] LINK_END  = {LW{1'b1}} - LW'(1);

  // Divide by the block size through a reciprocal multiply; exact below 2**CW.
  function automatic logic [CW-1:0] div_bb(input logic [CW-1:0] x);
    logic [PW-1:0] p;
    p = PW'(x) * PW'(RECIP);
    return CW'(p >> SH);
  endfunction

  // Configuration
  logic [5:0] blocks_in_use;
  logic [4:0] files_in_use;

  // Tables
  logic [LW-1:0]  link      [BLOCK_COUNT];
  logic           used      [NUM_FILES];
  logic [BW-1:0]  first_blk [NUM_FILES];
  logic [10:0]    flen      [NUM_FILES];

  // Request registers
  lbcs_pkg::req_t    r_type;
  logic [3:0]        r_fid;
  logic [9:0]        r_pos;
  logic [10:0]       r_cnt;
  logic [7:0]        r_data;
  lbcs_pkg::status_t r_status;
  logic [7:0]        r_rdata;

  // Work registers
  logic [CW-1:0]  r_need, r_k, r_off;
  logic [CW-1:0]  idx, nfree, n, target, s, len;
  logic [FCW-1:0] fidx;
  logic [BW-1:0]  cur, tail;
  logic [LW-1:0]  nxt;
  logic           has_tail;
  logic [AW-1:0]  clr;

  logic              out_valid;
  lbcs_pkg::status_t o_status;
  logic [3:0]        o_file;
  logic [7:0]        o_rdata;
  logic [10:0]       o_size;

  // Derived values
  logic [CW-1:0] eff_b, eff_f;
  logic [BW-1:0] lrd_addr;
  logic [LW-1:0] lrd;
  logic [FIW-1:0] fid_ix, fs_ix;
  logic          free_hit, fid_ok;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [7:0]    ram_wdata, ram_q;

  assign eff_b = (CW'(blocks_in_use) > CW'(BLOCK_COUNT)) ? CW'(BLOCK_COUNT) : CW'(blocks_in_use);
  assign eff_f = (CW'(files_in_use) > CW'(NUM_FILES)) ? CW'(NUM_FILES) : CW'(files_in_use);

  assign fid_ix = FIW'(r_fid);
  assign fs_ix  = FIW'(fidx);

  always_comb begin
    unique case (cmd.op)
      lbcs_pkg::OP_COUNT, lbcs_pkg::OP_APPEND: lrd_addr = idx[BW-1:0];
      lbcs_pkg::OP_CUT:                        lrd_addr = nxt[BW-1:0];
      default:                                 lrd_addr = cur;
    endcase
  end

  assign lrd      = link[lrd_addr];
  assign free_hit = (lrd == LINK_FREE);
  assign fid_ok   = (CW'(r_fid) < eff_f) && used[fid_ix];

  assign stat.req_type    = r_type;
  assign stat.clr_last    = (clr == AW'(DEPTH - 1));
  assign stat.fs_fail     = (CW'(fidx) >= eff_f);
  assign stat.fs_hit      = (CW'(fidx) < eff_f) && !used[fs_ix];
  assign stat.chk_bad     = !fid_ok;
  assign stat.len_more    = (CW'(lrd) < CW'(BLOCK_COUNT)) && (len < CW'(BLOCK_COUNT));
  assign stat.need_gt_len = (r_need > len);
  assign stat.need_lt_len = (r_need < len);
  assign stat.k_ge_len    = (r_k >= len);
  assign stat.cnt_end     = (idx >= eff_b);
  assign stat.short_free  = (nfree < n);
  assign stat.app_last    = free_hit && (n == CW'(1));
  assign stat.nth_more    = (s < target) && (CW'(lrd) < CW'(BLOCK_COUNT));
  assign stat.cut_more    = (CW'(nxt) < CW'(BLOCK_COUNT)) && (s < CW'(BLOCK_COUNT));
  assign stat.out_busy    = out_valid && !m_tready;

  assign ram_we    = (cmd.op == lbcs_pkg::OP_CLEAR) || (cmd.op == lbcs_pkg::OP_WRITE);
  assign ram_wdata = (cmd.op == lbcs_pkg::OP_CLEAR) ? 8'd0 : r_data;
  assign ram_addr  = (cmd.op == lbcs_pkg::OP_CLEAR) ? clr :
                     AW'(cur) * AW'(BLOCK_BYTES) + AW'(r_off);

  lbcs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bytes (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, o_size, o_rdata, o_file, o_status};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= 6'd32;
      files_in_use  <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lbcs_pkg::CFG_BLOCKS: blocks_in_use <= cfg_data;
        lbcs_pkg::CFG_FILES:  files_in_use  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Tables and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        link[i] <= LINK_FREE;
      end
      for (int i = 0; i < NUM_FILES; i++) begin
        used[i]      <= 1'b0;
        first_blk[i] <= '0;
        flen[i]      <= '0;
      end
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result once the previous one has gone, else drop it on handoff.
      if (cmd.op == lbcs_pkg::OP_FINISH && !stat.out_busy) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        lbcs_pkg::OP_CLEAR: clr <= clr + AW'(1);
        lbcs_pkg::OP_APPEND: begin
          if (free_hit) begin
            link[idx[BW-1:0]] <= LINK_END;
            if (has_tail) begin
              link[tail] <= LW'(idx[BW-1:0]);
            end else begin
              first_blk[fs_ix] <= idx[BW-1:0];
            end
          end
        end
        lbcs_pkg::OP_CUT: begin
          if (stat.cut_more) begin
            link[nxt[BW-1:0]] <= LINK_FREE;
          end else begin
            link[tail] <= LINK_END;
          end
        end
        lbcs_pkg::OP_UPDATE: begin
          if (r_status == lbcs_pkg::ST_OK) begin
            case (r_type)
              lbcs_pkg::REQ_ALLOC: begin
                used[fs_ix] <= 1'b1;
                flen[fs_ix] <= r_cnt;
              end
              lbcs_pkg::REQ_RESIZE: flen[fid_ix] <= r_cnt;
              lbcs_pkg::REQ_WRITE: begin
                if ({1'b0, r_pos} >= flen[fid_ix]) begin
                  flen[fid_ix] <= 11'(r_pos) + 11'd1;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Request and work registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_type   <= lbcs_pkg::req_t'(s_tdata[1:0]);
      r_fid    <= s_tdata[5:2];
      r_pos    <= s_tdata[15:6];
      r_cnt    <= s_tdata[26:16];
      r_data   <= s_tdata[34:27];
      r_status <= lbcs_pkg::ST_OK;
      r_rdata  <= 8'd0;
      fidx     <= '0;
      has_tail <= (lbcs_pkg::req_t'(s_tdata[1:0]) != lbcs_pkg::REQ_ALLOC);
    end
    case (cmd.op)
      lbcs_pkg::OP_DISPATCH: begin
        r_k    <= div_bb(CW'(r_pos));
        r_need <= (r_cnt == 11'd0) ? CW'(1) : div_bb(CW'(r_cnt) + CW'(BLOCK_BYTES - 1));
      end
      lbcs_pkg::OP_FSCAN: begin
        if (stat.fs_fail) begin
          r_status <= lbcs_pkg::ST_NO_FILE;
        end else if (stat.fs_hit) begin
          n     <= r_need;
          idx   <= '0;
          nfree <= '0;
        end else begin
          fidx <= fidx + FCW'(1);
        end
      end
      lbcs_pkg::OP_CHECK: begin
        if (!fid_ok) r_status <= lbcs_pkg::ST_UNUSED;
        cur   <= first_blk[fid_ix];
        len   <= CW'(1);
        r_off <= CW'(r_pos) - r_k * CW'(BLOCK_BYTES);
      end
      lbcs_pkg::OP_LEN: begin
        if (stat.len_more) begin
          cur <= lrd[BW-1:0];
          len <= len + CW'(1);
        end else begin
          tail <= cur;
        end
      end
      lbcs_pkg::OP_DECIDE: begin
        idx   <= '0;
        nfree <= '0;
        if (r_type == lbcs_pkg::REQ_RESIZE) begin
          n      <= r_need - len;
          target <= r_need - CW'(1);
        end else begin
          n      <= r_k - len + CW'(1);
          target <= r_k;
        end
        if (r_type == lbcs_pkg::REQ_READ && stat.k_ge_len) begin
          r_status <= lbcs_pkg::ST_PAST_END;
        end
      end
      lbcs_pkg::OP_COUNT: begin
        if (!stat.cnt_end) begin
          if (free_hit) nfree <= nfree + CW'(1);
          idx <= idx + CW'(1);
        end
      end
      lbcs_pkg::OP_CHKFREE: begin
        if (stat.short_free) r_status <= lbcs_pkg::ST_NO_BLOCK;
        idx <= '0;
      end
      lbcs_pkg::OP_APPEND: begin
        if (free_hit) begin
          tail     <= idx[BW-1:0];
          has_tail <= 1'b1;
          n        <= n - CW'(1);
        end
        idx <= idx + CW'(1);
      end
      lbcs_pkg::OP_NTH0: begin
        cur <= first_blk[fid_ix];
        s   <= '0;
      end
      lbcs_pkg::OP_NTH: begin
        if (stat.nth_more) begin
          cur <= lrd[BW-1:0];
          s   <= s + CW'(1);
        end
      end
      lbcs_pkg::OP_CUT0: begin
        tail <= cur;
        nxt  <= lrd;
        s    <= '0;
      end
      lbcs_pkg::OP_CUT: begin
        if (stat.cut_more) begin
          nxt <= lrd;
          s   <= s + CW'(1);
        end
      end
      lbcs_pkg::OP_READ2: r_rdata <= ram_q;
      default: ;
    endcase
  end

  // Result register: load once the previous result has gone
  always_ff @(posedge clk) begin
    if (cmd.op == lbcs_pkg::OP_FINISH && !stat.out_busy) begin
      o_status <= r_status;
      o_rdata  <= r_rdata;
      if (r_type == lbcs_pkg::REQ_ALLOC) begin
        o_file <= (r_status == lbcs_pkg::ST_OK) ? 4'(fidx) : 4'd0;
        o_size <= (r_status == lbcs_pkg::ST_OK) ? r_cnt : 11'd0;
      end else begin
        o_file <= r_fid;
        o_size <= (r_status == lbcs_pkg::ST_UNUSED) ? 11'd0 : flen[fid_ix];
      end
    end
  end

endmodule

/* rtl/linked_block_chain_store.sv */
// Top level of the linked block chain store (FAT-style block chains).
// Depends on lbcs_pkg, lbcs_ctrl, lbcs_dp (and lbcs_ram through lbcs_dp).
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata: one request
//  m_*       out        m_tvalid / m_tready  m_tdata: one result per request
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request at a time. A request runs through its sequencer states plus the
// chain walk (one link per cycle), plus a free-block count over the managed
// blocks and an append scan when blocks are taken, plus a second walk to the
// target block. The single read port of the link table sets this pace.
// After reset the byte memory is cleared, one byte per cycle; s_tready stays
// low meanwhile, while configuration writes are taken. A finished result
// waits in the output register; the next request is accepted while it waits.
module linked_block_chain_store #(
  parameter int BLOCK_COUNT = 32,
  parameter int BLOCK_BYTES = 32,
  parameter int NUM_FILES   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[1:0], file_id[5:2], position[15:6], byte_count[26:16],
  // write_data[34:27], zero fill above
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], result_file[6:3], read_data[14:7], file_size[25:15],
  // zero fill above
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  lbcs_pkg::cmd_t  cmd;
  lbcs_pkg::stat_t stat;

  // Registers accept a write in any cycle.
  assign cfg_ready = 1'b1;

  lbcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbcs_dp #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_FILES   (NUM_FILES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

`ifndef NO_ASSERTIONS
  // A request is worked on alone: no second accept right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'd4))
    else $error("undefined status code");

  // Only a successful request may carry read data.
  a_rdata_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != 3'd0) |-> (m_tdata[14:7] == 8'd0))
    else $error("read data on a failed request");
`endif

endmodule
